@@ hw/rtl/rlsc_pkg.sv @@
`timescale 1ns / 1ps

package rlsc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_COUNT  = 2'd0;
    localparam logic [1:0] CFG_PERIOD_FRAMES = 2'd1;
    localparam logic [1:0] CFG_AVG_INTERVAL  = 2'd2;

    // register reset values
    localparam logic [7:0] RST_REGION_COUNT  = 8'd0;
    localparam logic [7:0] RST_PERIOD_FRAMES = 8'd60;
    localparam logic [7:0] RST_AVG_INTERVAL  = 8'd10;

    // queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        LS_ON      = 2'd0,
        LS_OFF     = 2'd1,
        LS_BLINK   = 2'd2,
        LS_UNKNOWN = 2'd3
    } t_light;

    typedef struct packed {
        logic [6:0]  region;
        logic [7:0]  brightness;
        logic [15:0] frame_mean;
        logic        first_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [6:0] region_out;
        logic [1:0] light_state;
        logic       reclassified;
    } t_out_item;

    // per-region record held in the region memory
    typedef struct packed {
        logic [7:0] min_val;
        logic [7:0] max_val;
        t_light     state;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{min_val: 8'hFF, max_val: 8'h00, state: LS_UNKNOWN};

    // word handed from front to back
    typedef struct packed {
        logic [6:0]  region;
        logic [7:0]  brightness;
        logic [15:0] mean_level;
        logic        classify;
        logic        in_use;
        logic        in_range;
    } t_job;

endpackage

@@ hw/rtl/rlsc_ram.sv @@
`timescale 1ns / 1ps

module rlsc_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/rlsc_front.sv @@
`timescale 1ns / 1ps

module rlsc_front import rlsc_pkg::*; #(
    parameter int MAX_REGIONS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_push_valid,
    input  logic       i_push_ready,
    output t_job       o_push_data
);

    logic [7:0]  r_region_count;
    logic [7:0]  r_period_frames;
    logic [7:0]  r_avg_interval;
    logic [7:0]  r_avg_phase, n_avg_phase;
    logic [7:0]  r_period_phase, n_period_phase;
    logic [15:0] r_mean_level, n_mean_level;
    logic        r_classify, n_classify;
    logic        accept;
    logic        avg_wrap;
    logic        period_wrap;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count  <= RST_REGION_COUNT;
            r_period_frames <= RST_PERIOD_FRAMES;
            r_avg_interval  <= RST_AVG_INTERVAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REGION_COUNT:  r_region_count  <= i_cfg_data;
                CFG_PERIOD_FRAMES: r_period_frames <= i_cfg_data;
                CFG_AVG_INTERVAL:  r_avg_interval  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_in_valid && i_push_ready;

    // frame start: advance the average and period phases, latch the mean and set the classify flag on a wrap
    always_comb begin
        avg_wrap    = ({1'b0, r_avg_phase} + 9'd1) >= {1'b0, r_avg_interval};
        period_wrap = ({1'b0, r_period_phase} + 9'd1) >= {1'b0, r_period_frames};
        n_avg_phase    = r_avg_phase;
        n_period_phase = r_period_phase;
        n_mean_level   = r_mean_level;
        n_classify     = r_classify;
        if (accept && i_in.first_of_frame) begin
            if (avg_wrap) begin
                n_mean_level = i_in.frame_mean;
                n_avg_phase  = 8'd0;
            end else begin
                n_avg_phase = r_avg_phase + 8'd1;
            end
            if (period_wrap) begin
                n_classify     = 1'b1;
                n_period_phase = 8'd0;
            end else begin
                n_classify     = 1'b0;
                n_period_phase = r_period_phase + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_phase    <= 8'd0;
            r_period_phase <= 8'd0;
            r_mean_level   <= 16'd0;
            r_classify     <= 1'b0;
        end else begin
            r_avg_phase    <= n_avg_phase;
            r_period_phase <= n_period_phase;
            r_mean_level   <= n_mean_level;
            r_classify     <= n_classify;
        end
    end

    // tag the word with what the back part needs to know
    always_comb begin
        o_push_data.region     = i_in.region;
        o_push_data.brightness = i_in.brightness;
        o_push_data.mean_level = (i_in.first_of_frame && avg_wrap) ? i_in.frame_mean
                                                                   : r_mean_level;
        o_push_data.classify   = i_in.first_of_frame ? period_wrap : r_classify;
        o_push_data.in_range   = 32'(i_in.region) < MAX_REGIONS;
        o_push_data.in_use     = o_push_data.in_range
                                 && ({1'b0, i_in.region} < r_region_count);
    end

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

@@ hw/rtl/rlsc_fifo.sv @@
`timescale 1ns / 1ps

module rlsc_fifo import rlsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != (PTR_W + 1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_slot[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_data;
        end
    end

endmodule

@@ hw/rtl/rlsc_back.sv @@
`timescale 1ns / 1ps

module rlsc_back import rlsc_pkg::*; #(
    parameter int MAX_REGIONS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_pop_valid,
    output logic      o_pop_ready,
    input  t_job      i_pop_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    logic                   r_s2_vld;
    t_job                   r_s2_job;
    logic                   r_fwd_hit;
    t_entry                 r_fwd_data;
    logic [MAX_REGIONS-1:0] r_written;
    logic [15:0]            r_lit, n_lit;
    logic                   r_out_vld;
    t_out_item              r_out, n_out;

    logic          commit;
    logic          pop;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_entry        wr_data;
    t_entry        ram_rdata;
    t_entry        cur;
    logic [7:0]    hi;
    logic [7:0]    lo;
    logic [7:0]    lo_floor;
    logic          blink;
    logic          lit_on;
    logic          mean_on;
    logic [16:0]   lit_sum;
    t_light        new_state;

    // pipeline advance
    assign commit      = r_s2_vld && (!r_out_vld || i_out_ready);
    assign pop         = i_pop_valid && (!r_s2_vld || commit);
    assign o_pop_ready = !r_s2_vld || commit;

    assign rd_addr = AW'(i_pop_data.region);
    assign wr_addr = AW'(r_s2_job.region);
    assign wr_en   = commit && r_s2_job.in_use;

    rlsc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_REGIONS)
    ) u_region_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (pop),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    // current record: last write forwarded, unwritten entries read as reset
    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_written[wr_addr]) begin
            cur = ram_rdata;
        end else begin
            cur = ENTRY_RESET;
        end
    end

    // fold in the sample and classify
    always_comb begin
        hi       = (r_s2_job.brightness > cur.max_val) ? r_s2_job.brightness : cur.max_val;
        lo       = (r_s2_job.brightness < cur.min_val) ? r_s2_job.brightness : cur.min_val;
        lo_floor = (lo == 8'd0) ? 8'd1 : lo;
        blink    = (13'(hi) * 13'd10) > (13'(lo_floor) * 13'd19);
        lit_on   = (20'(hi) * 20'd2560) >= 20'({r_lit, 3'b000});
        mean_on  = (20'(hi) * 20'd2560) > (20'(r_s2_job.mean_level) * 20'd12);
        lit_sum  = 17'(r_lit) + 17'({hi, 8'h00});

        n_lit = r_lit;
        if (blink) begin
            new_state = LS_BLINK;
        end else if (r_lit != 16'd0) begin
            new_state = lit_on ? LS_ON : LS_OFF;
        end else begin
            new_state = mean_on ? LS_ON : LS_OFF;
        end

        if (r_s2_job.classify) begin
            wr_data.min_val = 8'hFF;
            wr_data.max_val = 8'h00;
            wr_data.state   = new_state;
            if (blink && wr_en) begin
                n_lit = (r_lit == 16'd0) ? {hi, 8'h00} : lit_sum[16:1];
            end
        end else begin
            wr_data.min_val = lo;
            wr_data.max_val = hi;
            wr_data.state   = cur.state;
        end

        n_out.region_out = r_s2_job.region;
        if (!r_s2_job.in_range) begin
            n_out.light_state = LS_UNKNOWN;
        end else if (r_s2_job.in_use) begin
            n_out.light_state = wr_data.state;
        end else begin
            n_out.light_state = cur.state;
        end
        n_out.reclassified = r_s2_job.in_use && r_s2_job.classify;
    end

    // stage control, forwarding and written marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_written <= '0;
            r_lit     <= 16'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_s2_vld  <= 1'b1;
                r_fwd_hit <= wr_en && (wr_addr == rd_addr);
            end else if (commit) begin
                r_s2_vld <= 1'b0;
            end
            if (wr_en) begin
                r_written[wr_addr] <= 1'b1;
            end
            r_lit <= n_lit;
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s2_job   <= i_pop_data;
            r_fwd_data <= wr_data;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // a write that lands on the address being read must be forwarded
    a_fwd_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && wr_en && (wr_addr == rd_addr)) |=> r_fwd_hit)
        else $error("same-address write not forwarded");

    // a reclassified region never reports unknown
    a_recl_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.reclassified) |-> (r_out.light_state != LS_UNKNOWN))
        else $error("reclassified region reported unknown");

    // a blink result leaves a lit level behind
    a_blink_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.reclassified && (r_out.light_state == LS_BLINK))
        |-> (r_lit != 16'd0))
        else $error("blinking region left no lit level");

    // once known, the lit level never returns to zero
    a_lit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_lit) != 16'd0) |-> (r_lit != 16'd0))
        else $error("lit level dropped to zero");

endmodule

@@ hw/rtl/region_light_state_classifier_core.sv @@
`timescale 1ns / 1ps

// Region light state classifier. Takes one word per region per frame (region
// index, integer brightness, frame mean in U8.8, first-of-frame flag) and
// returns one word per input: the region's state (on, off, blinking, unknown)
// and whether this word reclassified it. Sustained rate is one word per clock
// while the output is not held; that figure is set by the read-modify-write of
// the region memory, which forwards the last write so that back-to-back words
// on the same region work. An accepted word is written into the queue, read from
// the region memory into the stage register as it leaves the queue and lands in
// the output register when that stage commits. A four-deep queue
// separates the front (frame phases, mean latch, range checks) from the back
// (memory update, classification, lit level), so either side can stall alone.
// Region records start at their reset value through per-entry written marks,
// so no clearing pass follows reset. Configuration writes are always taken and
// must only be issued while the block is idle.
module region_light_state_classifier_core import rlsc_pkg::*; #(
    parameter int MAX_REGIONS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic push_valid;
    logic push_ready;
    t_job push_data;
    logic pop_valid;
    logic pop_ready;
    t_job pop_data;

    assign o_cfg_ready = 1'b1;

    // frame tracking and word tagging
    rlsc_front #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // decoupling queue
    rlsc_fifo u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // region memory update and classification
    rlsc_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
